FILE: rtl/utxq_pkg.sv
// ----------------------------------------------------------------------------
// utxq_pkg
// Shared constants and types for the transmit queue with newline expansion.
// ----------------------------------------------------------------------------
package utxq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam logic [7:0] LINE_FEED       = 8'h0A;
	localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

	typedef enum logic {
		MODE_ENQUEUE = 1'b0,
		MODE_DONE    = 1'b1
	} mode_t;

	typedef struct packed {
		logic pop;
		logic load;
	} cell_ctl_t;

endpackage

FILE: rtl/utxq_if.sv
// ----------------------------------------------------------------------------
// utxq_if
// Valid/ready channels for the event input and the result output.
// ----------------------------------------------------------------------------
interface utxq_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface utxq_out_if;
	logic       valid;
	logic       ready;
	logic       send;
	logic [7:0] tx_byte;
	logic       rejected;
	logic       idle;

	modport source (output valid, output send, output tx_byte, output rejected,
		output idle, input ready);
	modport sink   (input valid, input send, input tx_byte, input rejected,
		input idle, output ready);
endinterface

FILE: rtl/utxq_cell.sv
// ----------------------------------------------------------------------------
// utxq_cell
// One byte slot of the queue chain; loads a new byte or takes its neighbor's
// byte when the head is popped.
// ----------------------------------------------------------------------------
module utxq_cell (
	input  logic                 clk,
	input  utxq_pkg::cell_ctl_t  ctl,
	input  logic [7:0]           load_byte,
	input  logic [7:0]           next_byte,
	output logic [7:0]           cell_byte
);
	import utxq_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= load_byte;
		end else if (ctl.pop) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;

endmodule

FILE: rtl/uart_tx_queue_newline_expand_unit.sv
// ----------------------------------------------------------------------------
// uart_tx_queue_newline_expand_unit
// Transmit queue in front of a serial transmitter with line feed expansion.
// ----------------------------------------------------------------------------
// result: each accepted event beat gives a registered result beat in the next cycle
// throughput: one event per cycle while results are taken; the byte cell chain
//   shifts toward the head on each pop, so every step is one cell update
// reset: count, idle mark, pending carriage return and output valid reset at
//   once; the byte cells hold no reset and are only read once written
module uart_tx_queue_newline_expand_unit #(
	parameter int QUEUE_DEPTH = utxq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	utxq_in_if.sink   item,
	utxq_out_if.source result
);
	import utxq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          tx_idle_q;
	logic          cr_pending_q;

	logic          out_valid_q;
	logic          send_q;
	logic [7:0]    tx_byte_q;
	logic          rejected_q;
	logic          idle_q;

	logic          fire;
	logic          empty;
	logic          full;
	logic [7:0]    head_byte;

	logic          push;
	logic          pop;
	logic [CW-1:0] count_d;
	logic          tx_idle_d;
	logic          cr_pending_d;
	logic          send_d;
	logic [7:0]    tx_byte_d;
	logic          rejected_d;

	logic [7:0]    cell_bytes [QUEUE_DEPTH];

	assign item.ready = !out_valid_q || result.ready;
	assign fire       = item.valid && item.ready;
	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_byte  = cell_bytes[0];

	always_comb begin
		push         = 1'b0;
		pop          = 1'b0;
		tx_idle_d    = tx_idle_q;
		cr_pending_d = cr_pending_q;
		send_d       = 1'b0;
		tx_byte_d    = '0;
		rejected_d   = 1'b0;
		case (mode_t'(item.mode))
			MODE_ENQUEUE: begin
				if (tx_idle_q && empty) begin
					send_d    = 1'b1;
					tx_byte_d = item.data_byte;
					tx_idle_d = 1'b0;
					if (item.data_byte == LINE_FEED) begin
						push         = 1'b1;
						cr_pending_d = 1'b1;
					end else begin
						cr_pending_d = 1'b0;
					end
				end else if (full) begin
					rejected_d = 1'b1;
				end else begin
					push = 1'b1;
				end
			end
			MODE_DONE: begin
				if (empty) begin
					tx_idle_d    = 1'b1;
					cr_pending_d = 1'b0;
				end else begin
					tx_idle_d = 1'b0;
					send_d    = 1'b1;
					if (cr_pending_q) begin
						tx_byte_d    = CARRIAGE_RETURN;
						cr_pending_d = 1'b0;
						pop          = 1'b1;
					end else if (head_byte == LINE_FEED) begin
						tx_byte_d    = LINE_FEED;
						cr_pending_d = 1'b1;
					end else begin
						tx_byte_d = head_byte;
						pop       = 1'b1;
					end
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (fire && push) begin
			count_d = count_q + CW'(1);
		end else if (fire && pop) begin
			count_d = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t  ctl;
		logic [7:0] next_byte;

		assign ctl.pop  = fire && pop;
		assign ctl.load = fire && push && (count_q == CW'(i));

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_byte = '0;
		end else begin : g_link
			assign next_byte = cell_bytes[i+1];
		end

		utxq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_byte (item.data_byte),
			.next_byte (next_byte),
			.cell_byte (cell_bytes[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			tx_idle_q    <= 1'b1;
			cr_pending_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				count_q      <= count_d;
				tx_idle_q    <= tx_idle_d;
				cr_pending_q <= cr_pending_d;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			send_q     <= send_d;
			tx_byte_q  <= tx_byte_d;
			rejected_q <= rejected_d;
			idle_q     <= tx_idle_d;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.send     = send_q;
	assign result.tx_byte  = tx_byte_q;
	assign result.rejected = rejected_q;
	assign result.idle     = idle_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_cr_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cr_pending_q |-> !empty)
		else $error("carriage return pending with empty queue");

	a_reject_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rejected_q |-> !send_q)
		else $error("rejected beat also sends");

	a_idle_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && idle_q |-> !send_q && empty)
		else $error("idle beat sends or queue not empty");

endmodule
